### hw/rtl/itrd_pkg.sv
// Shared types, constants and lookup functions for the radix digit converter.
`timescale 1ns / 1ps

package itrd_pkg;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned RADIX_BITS = 5;
  localparam int unsigned RECIP_BITS = 32;

  localparam logic [RADIX_BITS-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX = 5'd16;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  // Offset so that a digit value of ten lands on the lower-case letter a.
  localparam logic [6:0] CHAR_ALPHA = 7'h57;
  localparam logic [6:0] CHAR_ERROR = 7'h00;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_BITS-1:0] radix;
    logic [RECIP_BITS-1:0] recip;
    logic                  bad;
  } entry_t;

  // floor(2^32 / radix); the back end corrects the one-low quotient this can give.
  function automatic logic [RECIP_BITS-1:0] recip(input logic [RADIX_BITS-1:0] radix);
    logic [RECIP_BITS-1:0] r;
    case (radix)
      5'd2:    r = 32'h8000_0000;
      5'd3:    r = 32'h5555_5555;
      5'd4:    r = 32'h4000_0000;
      5'd5:    r = 32'h3333_3333;
      5'd6:    r = 32'h2AAA_AAAA;
      5'd7:    r = 32'h2492_4924;
      5'd8:    r = 32'h2000_0000;
      5'd9:    r = 32'h1C71_C71C;
      5'd10:   r = 32'h1999_9999;
      5'd11:   r = 32'h1745_D174;
      5'd12:   r = 32'h1555_5555;
      5'd13:   r = 32'h13B1_3B13;
      5'd14:   r = 32'h1249_2492;
      5'd15:   r = 32'h1111_1111;
      5'd16:   r = 32'h1000_0000;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] glyph(input logic [3:0] digit);
    logic [6:0] c;
    if (digit < 4'd10) begin
      c = CHAR_ZERO + {3'b000, digit};
    end else begin
      c = CHAR_ALPHA + {3'b000, digit};
    end
    return c;
  endfunction

endpackage

### hw/rtl/integer_to_radix_digits_core.sv
// Top level of the unsigned integer to radix 2..16 digit string converter.
//
//   Channel  Role    Beat contents (lowest bit first)
//   s_*      input   tdata: value[31:0], radix[36:32], zero pad[39:37]
//   m_*      output  tdata: digit_char[6:0], zero pad[7]; tlast: last_digit;
//                    tuser: bad_radix
//
// Each digit of a value takes one pass of the divide loop (ST_MUL multiplies by the
// radix reciprocal, ST_FIX makes the correction step); the digits then leave as beats read
// out of the digit store, most significant first.
// A bad radix gives a single error beat.
// The input queue holds two beats, so new input is taken while a conversion runs.
// Reset is synchronous and clears the queue, the engine state and the output valid flag.
// Output stalls hold the digit read-out and the taking of a bad-radix entry; the divide loop never waits on m_tready.
`timescale 1ns / 1ps

module integer_to_radix_digits_core #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // value[31:0], radix[36:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // digit_char[6:0]
  output logic        m_tlast,
  output logic        m_tuser    // bad_radix
);

  logic             q_full;
  logic             q_empty;
  logic             push;
  logic             pop;
  itrd_pkg::entry_t push_entry;
  itrd_pkg::entry_t head;

  itrd_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  itrd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty)
  );

  itrd_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (q_empty),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

### hw/rtl/itrd_front.sv
// Input side: takes beats, checks the radix and looks up its reciprocal.
`timescale 1ns / 1ps

module itrd_front (
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,
  input  logic                 q_full,
  output logic                 push,
  output itrd_pkg::entry_t     push_entry
);

  logic [itrd_pkg::RADIX_BITS-1:0] radix;

  assign radix    = s_tdata[36:32];
  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    push_entry.value = s_tdata[31:0];
    push_entry.radix = radix;
    push_entry.recip = itrd_pkg::recip(radix);
    push_entry.bad   = (radix < itrd_pkg::RADIX_MIN) || (radix > itrd_pkg::RADIX_MAX);
  end

endmodule

### hw/rtl/itrd_queue.sv
// Two-entry queue between the input side and the conversion engine.
`timescale 1ns / 1ps

module itrd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  itrd_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output itrd_pkg::entry_t head,
  output logic             empty
);

  itrd_pkg::entry_t                   slots [itrd_pkg::QUEUE_DEPTH];
  logic [itrd_pkg::QUEUE_PTR_W-1:0]   wr_ptr;
  logic [itrd_pkg::QUEUE_PTR_W-1:0]   rd_ptr;
  logic [itrd_pkg::QUEUE_CNT_W-1:0]   fill;

  assign full  = (fill == itrd_pkg::QUEUE_CNT_W'(itrd_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/itrd_back.sv
// Conversion engine: reciprocal-multiply division loop, digit store and output beat register.
`timescale 1ns / 1ps

module itrd_back #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  itrd_pkg::entry_t head,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tlast,
  output logic             m_tuser
);

  localparam int unsigned QW    = (VALUE_WIDTH < itrd_pkg::VALUE_BITS) ?
                                  VALUE_WIDTH : itrd_pkg::VALUE_BITS;
  localparam int unsigned RW    = itrd_pkg::RECIP_BITS;
  localparam int unsigned IDX_W = $clog2(QW);
  localparam int unsigned CNT_W = $clog2(QW + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                      state;
  logic [QW-1:0]                   quot;
  logic [RW-1:0]                   recip;
  logic [itrd_pkg::RADIX_BITS-1:0] radix;
  logic [QW-1:0]                   q_est;
  logic [CNT_W-1:0]                count;
  logic [CNT_W-1:0]                rptr;
  logic                            rd_valid;
  logic [3:0]                      rd_digit;
  logic                            rd_last;
  logic                            out_valid;
  logic [6:0]                      out_char;
  logic                            out_last;
  logic                            out_bad;

  logic [3:0]                      store [QW];

  logic [QW+RW-1:0]                prod;
  logic [10:0]                     qr_lo;
  logic [5:0]                      rem_raw;
  logic                            rem_fix;
  logic [5:0]                      rem_adj;
  logic [QW-1:0]                   q_next;
  logic [CNT_W-1:0]                count_next;
  logic [CNT_W-1:0]                rptr_dec;
  logic                            out_free;
  logic                            consume;
  logic                            issue;
  logic                            load_err;
  logic                            load_dig;

  assign out_free = !out_valid || m_tready;
  assign pop      = (state == ST_IDLE) && !empty && (!head.bad || out_free);
  assign load_err = pop && head.bad;
  assign consume  = (state == ST_EMIT) && rd_valid && out_free;
  assign issue    = (state == ST_EMIT) && (rptr != '0) && (!rd_valid || consume);
  assign load_dig = consume;

  // The reciprocal estimate is never high and at most one low.
  assign prod = {{RW{1'b0}}, quot} * {{QW{1'b0}}, recip};

  // The true remainder is below 32, so six low bits are enough to form it.
  assign qr_lo      = {5'b00000, q_est[5:0]} * {6'b000000, radix};
  assign rem_raw    = quot[5:0] - qr_lo[5:0];
  assign rem_fix    = rem_raw >= {1'b0, radix};
  assign rem_adj    = rem_fix ? (rem_raw - {1'b0, radix}) : rem_raw;
  assign q_next     = q_est + QW'(rem_fix);
  assign count_next = count + CNT_W'(1);
  assign rptr_dec   = rptr - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (state == ST_FIX) begin
      store[count[IDX_W-1:0]] <= rem_adj[3:0];
    end
    if (issue) begin
      rd_digit <= store[rptr_dec[IDX_W-1:0]];
      rd_last  <= (rptr_dec == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      quot  <= head.value[QW-1:0];
      recip <= head.recip;
      radix <= head.radix;
    end else if (state == ST_FIX) begin
      quot <= q_next;
    end
    if (state == ST_MUL) begin
      q_est <= prod[QW+RW-1:RW];
    end
    if (load_err) begin
      out_char <= itrd_pkg::CHAR_ERROR;
      out_last <= 1'b1;
      out_bad  <= 1'b1;
    end else if (load_dig) begin
      out_char <= itrd_pkg::glyph(rd_digit);
      out_last <= rd_last;
      out_bad  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rptr      <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_err || load_dig) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop && !head.bad) begin
            count <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_FIX;
        end
        ST_FIX: begin
          count <= count_next;
          if (q_next == '0) begin
            rptr     <= count_next;
            rd_valid <= 1'b0;
            state    <= ST_EMIT;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_EMIT: begin
          if (issue) begin
            rptr     <= rptr_dec;
            rd_valid <= 1'b1;
          end else if (consume) begin
            rd_valid <= 1'b0;
          end
          if (consume && rd_last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_char};
  assign m_tlast  = out_last;
  assign m_tuser  = out_bad;

endmodule

### hw/rtl/itrd_checker.sv
// Port-level checks for the radix digit converter, bound to the top level.
`timescale 1ns / 1ps

module itrd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [39:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  // An error beat stands alone and carries no character.
  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'h00))
    else $error("error beat without tlast or with nonzero data");

  // Every digit beat is a lower-case hex character.
  a_digit_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |->
      ((m_tdata >= 8'h30) && (m_tdata <= 8'h39)) ||
      ((m_tdata >= 8'h61) && (m_tdata <= 8'h66)))
    else $error("digit beat outside 0-9 and a-f");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                              && $stable(m_tuser))
    else $error("stalled output beat changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind integer_to_radix_digits_core itrd_checker u_itrd_checker (.*);

### tb/sv/integer_to_radix_digits_core_tb.sv
// Self-checking testbench for the radix 2..16 digit string converter.
`timescale 1ns / 1ps

module integer_to_radix_digits_core_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 120;
  localparam int RANDOM_ITEMS   = 280;
  localparam logic [6:0] ASCII_ZERO = 7'h30;
  localparam logic [6:0] ASCII_LC_A = 7'h61;

  typedef struct {
    logic [31:0] value;
    logic [4:0]  radix;
    int          gap;
  } conversion_t;

  typedef struct {
    logic [6:0] digit_char;
    logic       last_digit;
    logic       bad_radix;
  } digit_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // value[31:0], radix[36:32]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;       // digit_char[6:0]
  logic        m_tlast;
  logic        m_tuser;       // bad_radix

  conversion_t conversions_to_send[$];
  digit_beat_t pending_digits[$];

  int errors = 0;
  int values_sent = 0;
  int digits_seen = 0;
  int bad_radix_seen = 0;
  int cycle_count = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  int radix_hits[32];

  integer_to_radix_digits_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Digits of value in the given base, most significant first; one error beat for a bad base.
  task automatic predict_digits(input logic [31:0] value, input logic [4:0] radix);
    logic [3:0]  remainders[$];
    logic [31:0] q;
    logic [3:0]  d;
    digit_beat_t beat;
    if (radix < itrd_pkg::RADIX_MIN || radix > itrd_pkg::RADIX_MAX) begin
      beat.digit_char = 7'd0;
      beat.last_digit = 1'b1;
      beat.bad_radix  = 1'b1;
      pending_digits.push_back(beat);
      return;
    end
    q = value;
    do begin
      remainders.push_front(4'(q % radix));
      q = q / radix;
    end while (q != 0);
    for (int k = 0; k < remainders.size(); k++) begin
      d = remainders[k];
      beat.digit_char = (d < 4'd10) ? ASCII_ZERO + 7'(d) : ASCII_LC_A + 7'(d) - 7'd10;
      beat.last_digit = (k == remainders.size() - 1);
      beat.bad_radix  = 1'b0;
      pending_digits.push_back(beat);
    end
  endtask

  task automatic queue_conversion(input logic [31:0] value, input logic [4:0] radix,
                                  input bit quiet);
    conversion_t c;
    c.value = value;
    c.radix = radix;
    c.gap   = quiet ? 0 : pick_gap();
    conversions_to_send.push_back(c);
  endtask

  function automatic logic [31:0] random_value(input logic [4:0] radix);
    int kind;
    int k;
    kind = $urandom_range(0, 4);
    k = $urandom_range(0, 31);
    case (kind)
      0: return $urandom();
      1: return $urandom_range(0, radix * radix + 1);
      2: return (32'd1 << k) - 32'd1;
      3: return 32'd1 << k;
      default: return $urandom() | 32'hF000_0000;
    endcase
  endfunction

  // Driver: presents queued conversions and records what the block will owe.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_digits(s_tdata[31:0], s_tdata[36:32]);
        values_sent++;
        radix_hits[s_tdata[36:32]]++;
      end
      if (s_tvalid && !s_tready) begin
        // Hold the beat until it is taken.
      end else if (gap_left > 0) begin
        s_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (conversions_to_send.size() > 0) begin
        conversion_t c;
        c = conversions_to_send.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, c.radix, c.value};
        gap_left <= c.gap;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure and a field-by-field check of each digit beat.
  always @(posedge clk) begin
    cycle_count++;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_digits.size() == 0) begin
          $display("%0t: unexpected beat char=%h last=%b bad=%b", $time,
                   m_tdata[6:0], m_tlast, m_tuser);
          errors++;
        end else begin
          digit_beat_t want;
          want = pending_digits.pop_front();
          if (m_tdata[6:0] !== want.digit_char) begin
            $display("%0t: digit_char expected %h actual %h", $time, want.digit_char,
                     m_tdata[6:0]);
            errors++;
          end
          if (m_tlast !== want.last_digit) begin
            $display("%0t: last_digit expected %b actual %b", $time, want.last_digit, m_tlast);
            errors++;
          end
          if (m_tuser !== want.bad_radix) begin
            $display("%0t: bad_radix expected %b actual %b", $time, want.bad_radix, m_tuser);
            errors++;
          end
          if (want.bad_radix) begin
            bad_radix_seen++;
          end else begin
            digits_seen++;
          end
        end
      end
      // Every third stretch of the run goes without back-pressure.
      if ((cycle_count / 2000) % 3 == 1) begin
        m_tready <= 1'b1;
        stall_left <= 0;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        m_tready <= 1'b1;
        stall_left <= pick_gap();
      end
    end
  end

  // Watchdog on cycles with no beat moving on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d beats still owed", $time,
               WATCHDOG_LIMIT, pending_digits.size());
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [4:0] radix;
    bit quiet;
    int bases_used;
    for (int i = 0; i < 32; i++) begin
      radix_hits[i] = 0;
    end

    // Directed: zero, all ones, single-digit edges, and out-of-range bases.
    queue_conversion(32'd0, 5'd2, 1'b0);
    queue_conversion(32'd0, 5'd10, 1'b0);
    queue_conversion(32'd0, 5'd16, 1'b0);
    queue_conversion(32'hFFFF_FFFF, 5'd2, 1'b0);
    queue_conversion(32'hFFFF_FFFF, 5'd16, 1'b0);
    queue_conversion(32'hFFFF_FFFF, 5'd3, 1'b0);
    queue_conversion(32'hFFFF_FFFF, 5'd0, 1'b0);
    queue_conversion(32'h0000_0000, 5'd1, 1'b0);
    queue_conversion(32'h1234_5678, 5'd17, 1'b0);
    queue_conversion(32'hFFFF_FFFF, 5'd31, 1'b0);
    queue_conversion(32'd15, 5'd16, 1'b0);
    queue_conversion(32'd16, 5'd16, 1'b0);
    queue_conversion(32'hDEAD_BEEF, 5'd16, 1'b0);
    for (int b = 4; b <= 15; b++) begin
      queue_conversion(32'(b * b - 1), 5'(b), 1'b1);
    end

    // Random: mostly valid bases with varied values, some bad bases.
    quiet = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 99) < 88) begin
        radix = 5'($urandom_range(itrd_pkg::RADIX_MIN, itrd_pkg::RADIX_MAX));
      end else if ($urandom_range(0, 1) == 0) begin
        radix = 5'($urandom_range(0, 1));
      end else begin
        radix = 5'($urandom_range(17, 31));
      end
      queue_conversion(random_value(radix), radix, quiet);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (conversions_to_send.size() > 0 || s_tvalid || pending_digits.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    bases_used = 0;
    for (int i = 0; i < 32; i++) begin
      if (radix_hits[i] > 0) begin
        bases_used++;
      end
    end
    $display("Converted %0d values over %0d distinct base codes.", values_sent, bases_used);
    $display("Checked %0d digit beats and %0d bad-base beats.", digits_seen, bad_radix_seen);
    if (errors == 0 && pending_digits.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
